[rtl/core/hta_pkg.sv]
`timescale 1ns / 1ps
// Handle table allocator package: sizes, operation and status codes.
// No dependencies; used by handle_table_allocator.
package hta_pkg;

    localparam int NUM_HANDLES = 256;
    localparam int HANDLE_BITS = $clog2(NUM_HANDLES);
    localparam int CNT_BITS    = HANDLE_BITS + 1;
    localparam int OBJ_BITS    = 16;   // stored object id width
    localparam int FIELD_BITS  = 8;    // handle fields on the ports
    localparam int OBJ_IN_BITS = 16;   // object_id field on the port

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_DUP    = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_UNMAPPED = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

endpackage

[rtl/core/hta_ram.sv]
`timescale 1ns / 1ps
// Simple dual-port RAM, one write and one registered read port.
// Stand-alone; used by handle_table_allocator for object and free-stack storage.
module hta_ram #(
    parameter int ADDR_BITS = 8,
    parameter int DATA_BITS = 8
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_BITS-1:0] rd_data
);

    logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/core/handle_table_allocator.sv]
`timescale 1ns / 1ps
// Handle table allocator: maps handles to object ids, with a LIFO of freed handles.
// Depends on hta_pkg and hta_ram.
//
// Usage:
//   Input items arrive on s_t* (operation in s_tuser, operands in s_tdata).
//   Each item yields exactly one result item on m_t* (handle and status).
//   One item is in work at a time; s_tready is high only while the block waits
//   for an item. A finished result sits in the output register, so the next
//   item is taken while that result still waits for m_tready.
// States from accept to m_tvalid:
//   remove, clear:          S_DECODE, S_RESP
//   insert from free stack: S_DECODE, S_ALLOC, S_POP, S_RESP; sequential search
//                           takes S_SCAN in place of S_POP, once per handle tried
//   dup with target:        S_DECODE, S_DUPRD, S_RESP, plus S_SRCH_RD and S_SRCH_CMP
//                           per free-stack entry searched to take the target out,
//                           and S_SRCH_MOVE when the target is found there
// The per-item cost is set by the registered read of the object and free-stack
// RAMs and by the one-entry-per-step stack search and handle scan.
// Reset empties the table (valid bits clear at once), empties the stack and
// sets the sequential counter to one; RAM contents need no clearing.
// A stalled receiver holds the result; a further item finishes its work and
// then waits until the output register is free.
module handle_table_allocator
    import hta_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // handle[7:0], has_target[8], target_handle[16:9],
                                  // object_id[32:17], zero fill
    input  logic [1:0]  s_tuser,  // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata   // result_handle[7:0], status[9:8], zero fill
);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_ALLOC, S_POP, S_SCAN, S_DUPRD,
        S_SRCH_RD, S_SRCH_CMP, S_SRCH_MOVE, S_RESP
    } state_t;

    state_t                  state_reg;
    op_t                     op_reg;
    logic [FIELD_BITS-1:0]   src_reg;
    logic                    has_t_reg;
    logic [FIELD_BITS-1:0]   tgt_reg;
    logic [OBJ_BITS-1:0]     obj_reg;
    logic [NUM_HANDLES-1:0]  valid_reg;
    logic [CNT_BITS-1:0]     cnt_reg;
    logic [CNT_BITS-1:0]     seq_reg;
    logic [CNT_BITS-1:0]     idx_reg;
    logic [FIELD_BITS-1:0]   res_reg;
    status_t                 st_reg;
    logic                    m_tvalid_reg;
    logic [FIELD_BITS-1:0]   m_handle_reg;
    status_t                 m_status_reg;

    // RAM ports
    logic                    stk_wr_en, stk_rd_en, obj_wr_en, obj_rd_en;
    logic [HANDLE_BITS-1:0]  stk_wr_addr, stk_rd_addr, obj_wr_addr, obj_rd_addr;
    logic [HANDLE_BITS-1:0]  stk_wr_data, stk_q;
    logic [OBJ_BITS-1:0]     obj_wr_data, obj_q;

    logic                    src_ok, tgt_ok, stk_empty, stk_full, seq_end;
    logic [HANDLE_BITS-1:0]  src_idx, tgt_idx, top_idx, seq_idx;

    assign src_ok    = 32'(src_reg) < NUM_HANDLES;
    assign tgt_ok    = 32'(tgt_reg) < NUM_HANDLES;
    assign src_idx   = HANDLE_BITS'(src_reg);
    assign tgt_idx   = HANDLE_BITS'(tgt_reg);
    assign top_idx   = HANDLE_BITS'(cnt_reg - 1'b1);
    assign seq_idx   = seq_reg[HANDLE_BITS-1:0];
    assign stk_empty = cnt_reg == '0;
    assign stk_full  = cnt_reg == CNT_BITS'(NUM_HANDLES);
    assign seq_end   = seq_reg >= CNT_BITS'(NUM_HANDLES);

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, m_status_reg, m_handle_reg};

    hta_ram #(.ADDR_BITS(HANDLE_BITS), .DATA_BITS(HANDLE_BITS)) u_stack (
        .aclk    (aclk),
        .wr_en   (stk_wr_en),
        .wr_addr (stk_wr_addr),
        .wr_data (stk_wr_data),
        .rd_en   (stk_rd_en),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_q)
    );

    hta_ram #(.ADDR_BITS(HANDLE_BITS), .DATA_BITS(OBJ_BITS)) u_objects (
        .aclk    (aclk),
        .wr_en   (obj_wr_en),
        .wr_addr (obj_wr_addr),
        .wr_data (obj_wr_data),
        .rd_en   (obj_rd_en),
        .rd_addr (obj_rd_addr),
        .rd_data (obj_q)
    );

    always_comb begin
        stk_wr_en   = 1'b0;
        stk_wr_addr = HANDLE_BITS'(cnt_reg);
        stk_wr_data = src_idx;
        stk_rd_en   = 1'b0;
        stk_rd_addr = top_idx;
        obj_wr_en   = 1'b0;
        obj_wr_addr = stk_q;
        obj_wr_data = obj_reg;
        obj_rd_en   = 1'b0;
        obj_rd_addr = src_idx;
        case (state_reg)
            S_DECODE: begin
                if (op_reg == OP_REMOVE && src_ok && valid_reg[src_idx] && !stk_full) begin
                    stk_wr_en = 1'b1;
                end
                if (op_reg == OP_DUP) begin
                    obj_rd_en = 1'b1;
                end
            end
            S_ALLOC: begin
                stk_rd_en = !stk_empty;
            end
            S_POP: begin
                obj_wr_en = 1'b1;
            end
            S_SCAN: begin
                if (!seq_end && !valid_reg[seq_idx]) begin
                    obj_wr_en   = 1'b1;
                    obj_wr_addr = seq_idx;
                end
            end
            S_DUPRD: begin
                if (has_t_reg && tgt_ok) begin
                    obj_wr_en   = 1'b1;
                    obj_wr_addr = tgt_idx;
                    obj_wr_data = obj_q;
                end
            end
            S_SRCH_RD: begin
                stk_rd_en   = 1'b1;
                stk_rd_addr = idx_reg[HANDLE_BITS-1:0];
            end
            S_SRCH_CMP: begin
                stk_rd_en = stk_q == tgt_idx;   // fetch the top to fill the hole
            end
            S_SRCH_MOVE: begin
                stk_wr_en   = 1'b1;
                stk_wr_addr = idx_reg[HANDLE_BITS-1:0];
                stk_wr_data = stk_q;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            valid_reg    <= '0;
            cnt_reg      <= '0;
            seq_reg      <= CNT_BITS'(1);
            m_tvalid_reg <= 1'b0;
        end else begin
            // the response state reloads the output register itself
            if (m_tvalid_reg && m_tready && state_reg != S_RESP) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg    <= op_t'(s_tuser);
                        src_reg   <= s_tdata[7:0];
                        has_t_reg <= s_tdata[8];
                        tgt_reg   <= s_tdata[16:9];
                        obj_reg   <= OBJ_BITS'(s_tdata[32:17]);
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    res_reg   <= '0;
                    st_reg    <= ST_OK;
                    state_reg <= S_RESP;
                    case (op_reg)
                        OP_INSERT: begin
                            state_reg <= S_ALLOC;
                        end
                        OP_REMOVE: begin
                            if (src_ok && valid_reg[src_idx]) begin
                                valid_reg[src_idx] <= 1'b0;
                                if (!stk_full) begin
                                    cnt_reg <= cnt_reg + 1'b1;
                                end
                                res_reg <= src_reg;
                            end else begin
                                st_reg <= ST_UNMAPPED;
                            end
                        end
                        OP_DUP: begin
                            if (src_ok && valid_reg[src_idx]) begin
                                state_reg <= S_DUPRD;
                            end else begin
                                st_reg <= ST_UNMAPPED;
                            end
                        end
                        OP_CLEAR: begin
                            valid_reg <= '0;
                            cnt_reg   <= '0;
                            seq_reg   <= CNT_BITS'(1);
                        end
                        default: begin
                        end
                    endcase
                end
                S_ALLOC: begin
                    if (!stk_empty) begin
                        cnt_reg   <= cnt_reg - 1'b1;
                        state_reg <= S_POP;
                    end else begin
                        state_reg <= S_SCAN;
                    end
                end
                S_POP: begin
                    valid_reg[stk_q] <= 1'b1;
                    res_reg          <= FIELD_BITS'(stk_q);
                    state_reg        <= S_RESP;
                end
                S_SCAN: begin
                    if (seq_end) begin
                        st_reg    <= ST_FULL;
                        state_reg <= S_RESP;
                    end else if (valid_reg[seq_idx]) begin
                        seq_reg <= seq_reg + 1'b1;
                    end else begin
                        // counter stays; the handle is skipped next time as occupied
                        valid_reg[seq_idx] <= 1'b1;
                        res_reg            <= FIELD_BITS'(seq_idx);
                        state_reg          <= S_RESP;
                    end
                end
                S_DUPRD: begin
                    if (!has_t_reg) begin
                        obj_reg   <= obj_q;
                        state_reg <= S_ALLOC;
                    end else if (!tgt_ok) begin
                        st_reg    <= ST_UNMAPPED;
                        state_reg <= S_RESP;
                    end else begin
                        valid_reg[tgt_idx] <= 1'b1;
                        res_reg            <= tgt_reg;
                        idx_reg            <= '0;
                        state_reg          <= stk_empty ? S_RESP : S_SRCH_RD;
                    end
                end
                S_SRCH_RD: begin
                    state_reg <= S_SRCH_CMP;
                end
                S_SRCH_CMP: begin
                    if (stk_q == tgt_idx) begin
                        state_reg <= S_SRCH_MOVE;
                    end else if (idx_reg + 1'b1 >= cnt_reg) begin
                        state_reg <= S_RESP;
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_SRCH_RD;
                    end
                end
                S_SRCH_MOVE: begin
                    cnt_reg   <= cnt_reg - 1'b1;
                    state_reg <= S_RESP;
                end
                S_RESP: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_handle_reg <= res_reg;
                        m_status_reg <= st_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_BITS'(NUM_HANDLES))
        else $error("free stack count beyond table size");

    a_seq_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_reg != '0)
        else $error("sequential counter reached handle zero");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_status_reg != ST_OK |-> m_handle_reg == '0)
        else $error("failed result carries a handle");

    a_pop_free: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_POP |-> !valid_reg[stk_q])
        else $error("popped handle is already mapped");

    a_resp_once: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_RESP && (!m_tvalid_reg || m_tready) |=> state_reg == S_IDLE && m_tvalid_reg)
        else $error("result not loaded on response");
`endif

endmodule

[dv/tb_handle_table_allocator.sv]
`timescale 1ns / 1ps
// Self-checking testbench for handle_table_allocator: directed and random op streams,
// checked item by item against a behavioral allocator model kept in this file.
// Depends on hta_pkg and the handle_table_allocator RTL.
module tb_handle_table_allocator;
    import hta_pkg::*;

    localparam int STALL_LIMIT  = 20000;  // cycles with no handshake on either side
    localparam int RANDOM_ITEMS = 1650;
    localparam int DRAIN_CYCLES = 100;

    typedef struct packed {
        logic [FIELD_BITS-1:0] hnd;
        status_t               st;
    } outcome_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // handle[7:0], has_target[8], target_handle[16:9],
                                  // object_id[32:17], zero fill
    logic [1:0]  s_tuser  = '0;   // operation[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // result_handle[7:0], status[9:8], zero fill

    handle_table_allocator u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // allocator model state
    bit                    map_valid [NUM_HANDLES];
    logic [OBJ_BITS-1:0]   map_obj   [NUM_HANDLES];
    logic [FIELD_BITS-1:0] free_lifo [NUM_HANDLES];
    int                    free_depth = 0;
    int                    seq_cursor = 1;

    outcome_t pending_results[$];
    int       mismatches  = 0;
    int       items_sent  = 0;
    int       burst_left  = 0;
    int       quiet_count = 0;

    // Pop the latest freed handle, else scan up from the cursor. The cursor is
    // left on the handle it hands out; the next scan steps over it.
    function automatic bit grab_handle(logic [OBJ_BITS-1:0] o,
                                       output logic [FIELD_BITS-1:0] h);
        h = '0;
        if (free_depth > 0) begin
            free_depth--;
            h = free_lifo[free_depth];
        end else begin
            while (seq_cursor < NUM_HANDLES && map_valid[seq_cursor])
                seq_cursor++;
            if (seq_cursor >= NUM_HANDLES)
                return 1'b0;
            h = seq_cursor[FIELD_BITS-1:0];
        end
        map_valid[h] = 1'b1;
        map_obj[h]   = o;
        return 1'b1;
    endfunction

    function automatic outcome_t predict_outcome(op_t op, logic [FIELD_BITS-1:0] src, bit ht,
                                                 logic [FIELD_BITS-1:0] tgt,
                                                 logic [OBJ_BITS-1:0] o);
        outcome_t              r;
        logic [FIELD_BITS-1:0] k;
        r.hnd = '0;
        r.st  = ST_OK;
        k     = '0;
        case (op)
            OP_INSERT: begin
                if (grab_handle(o, k))
                    r.hnd = k;
                else
                    r.st = ST_FULL;
            end
            OP_REMOVE: begin
                if (map_valid[src]) begin
                    map_valid[src] = 1'b0;
                    if (free_depth < NUM_HANDLES) begin
                        free_lifo[free_depth] = src;
                        free_depth++;
                    end
                    r.hnd = src;
                end else begin
                    r.st = ST_UNMAPPED;
                end
            end
            OP_DUP: begin
                if (!map_valid[src]) begin
                    r.st = ST_UNMAPPED;
                end else if (ht) begin
                    map_obj[tgt]   = map_obj[src];
                    map_valid[tgt] = 1'b1;
                    // first match swapped with the top, stack shrinks by one
                    for (int i = 0; i < free_depth; i++) begin
                        if (free_lifo[i] == tgt) begin
                            free_lifo[i] = free_lifo[free_depth-1];
                            free_depth--;
                            break;
                        end
                    end
                    r.hnd = tgt;
                end else if (grab_handle(map_obj[src], k)) begin
                    r.hnd = k;
                end else begin
                    r.st = ST_FULL;
                end
            end
            default: begin
                foreach (map_valid[i])
                    map_valid[i] = 1'b0;
                free_depth = 0;
                seq_cursor = 1;
            end
        endcase
        return r;
    endfunction

    function automatic logic [FIELD_BITS-1:0] pick_mapped();
        logic [FIELD_BITS-1:0] live[$];
        for (int i = 0; i < NUM_HANDLES; i++)
            if (map_valid[i])
                live.push_back(i[FIELD_BITS-1:0]);
        if (live.size() == 0)
            return FIELD_BITS'($urandom_range(NUM_HANDLES-1));
        return live[$urandom_range(live.size()-1)];
    endfunction

    function automatic logic [FIELD_BITS-1:0] pick_stacked();
        if (free_depth == 0)
            return pick_mapped();
        return free_lifo[$urandom_range(free_depth-1)];
    endfunction

    function automatic void log_mismatch(string what, outcome_t want, logic [15:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %0s: expected handle %0d status %0s, got handle %0d status %0d",
                     $time, what, want.hnd, want.st.name(), got[7:0], got[9:8]);
    endfunction

    // Drives one item at the falling edge, holds it until taken, then records
    // the expected result. Items go out in bursts with random gaps between.
    task automatic send_item(op_t op, logic [FIELD_BITS-1:0] h, bit ht,
                             logic [FIELD_BITS-1:0] t, logic [OBJ_IN_BITS-1:0] o);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'b0, o, t, ht, h};
        do
            @(posedge aclk);
        while (!s_tready);
        pending_results.push_back(predict_outcome(op, h, ht, t, o));
        items_sent++;
    endtask

    task automatic send_random_item(int ins_pct, int rem_pct, int dup_pct);
        int                    r;
        logic [FIELD_BITS-1:0] src;
        logic [FIELD_BITS-1:0] tgt;
        bit                    ht;
        r   = $urandom_range(99);
        src = ($urandom_range(99) < 85) ? pick_mapped()
                                        : FIELD_BITS'($urandom_range(NUM_HANDLES-1));
        ht  = 1'($urandom_range(1));
        case ($urandom_range(2))
            0:       tgt = pick_stacked();
            1:       tgt = pick_mapped();
            default: tgt = FIELD_BITS'($urandom_range(NUM_HANDLES-1));
        endcase
        if (r < ins_pct)
            send_item(OP_INSERT, FIELD_BITS'($urandom_range(255)), ht, tgt,
                      OBJ_IN_BITS'($urandom_range(65535)));
        else if (r < ins_pct + rem_pct)
            send_item(OP_REMOVE, src, ht, tgt, OBJ_IN_BITS'($urandom_range(65535)));
        else if (r < ins_pct + rem_pct + dup_pct)
            send_item(OP_DUP, src, ht, tgt, OBJ_IN_BITS'($urandom_range(65535)));
        else
            send_item(OP_CLEAR, FIELD_BITS'($urandom_range(255)), ht, tgt,
                      OBJ_IN_BITS'($urandom_range(65535)));
    endtask

    // empty table, object id extremes, LIFO reuse, sequential skip, clear
    task automatic test_basic_ops();
        send_item(OP_REMOVE, 8'd0,   1'b0, 8'd0, 16'h0000);  // remove on empty table
        send_item(OP_DUP,    8'd255, 1'b1, 8'd7, 16'h0000);  // dup of unmapped source
        send_item(OP_INSERT, 8'd0,   1'b0, 8'd0, 16'h0000);
        send_item(OP_INSERT, 8'hFF,  1'b1, 8'hFF, 16'hFFFF);
        send_item(OP_INSERT, 8'h5A,  1'b0, 8'hA5, 16'h1234);
        send_item(OP_REMOVE, 8'd2,   1'b0, 8'd0, 16'h0000);
        send_item(OP_INSERT, 8'd0,   1'b0, 8'd0, 16'hBEEF);  // reuses the freed handle
        send_item(OP_CLEAR,  8'd0,   1'b0, 8'd0, 16'h0000);
        send_item(OP_REMOVE, 8'd1,   1'b0, 8'd0, 16'h0000);  // gone after clear
        send_item(OP_INSERT, 8'd0,   1'b0, 8'd0, 16'h0001);
    endtask

    // dup: fresh handle, target zero and top handle, self, target on the free stack
    task automatic test_dup_cases();
        send_item(OP_INSERT, 8'd0, 1'b0, 8'd0,   16'h00AA);
        send_item(OP_DUP,    8'd1, 1'b0, 8'd0,   16'h0000);  // scan skips occupied handles
        send_item(OP_DUP,    8'd1, 1'b1, 8'd0,   16'h0000);
        send_item(OP_DUP,    8'd2, 1'b1, 8'd2,   16'h0000);  // onto itself
        send_item(OP_DUP,    8'd2, 1'b1, 8'd255, 16'h0000);
        send_item(OP_DUP,    8'd0, 1'b1, 8'd1,   16'h0000);  // replaces an occupied target
        send_item(OP_REMOVE, 8'd255, 1'b0, 8'd0, 16'h0000);
        send_item(OP_REMOVE, 8'd0,   1'b0, 8'd0, 16'h0000);
        send_item(OP_DUP,    8'd1, 1'b1, 8'd255, 16'h0000);  // target pulled off the stack
        send_item(OP_INSERT, 8'd0, 1'b0, 8'd0,   16'h5555);
        send_item(OP_INSERT, 8'd0, 1'b0, 8'd0,   16'hAAAA);
        send_item(OP_CLEAR,  8'hFF, 1'b1, 8'hFF, 16'hFFFF);
    endtask

    // fill every handle the counter reaches, then full answers and stack reuse
    task automatic test_fill_to_full();
        send_item(OP_CLEAR, 8'd0, 1'b0, 8'd0, 16'h0000);
        repeat (NUM_HANDLES)
            send_item(OP_INSERT, FIELD_BITS'($urandom_range(255)), 1'($urandom_range(1)),
                      FIELD_BITS'($urandom_range(255)), OBJ_IN_BITS'($urandom_range(65535)));
        send_item(OP_DUP, pick_mapped(), 1'b0, 8'd0, 16'h0000);
        send_item(OP_DUP, pick_mapped(), 1'b1, pick_mapped(), 16'h0000);
        repeat (4)
            send_item(OP_REMOVE, pick_mapped(), 1'b0, 8'd0, 16'h0000);
        send_item(OP_DUP, pick_mapped(), 1'b1, free_lifo[0], 16'h0000);
        send_item(OP_DUP, pick_mapped(), 1'b0, 8'd0, 16'h0000);
        repeat (3)
            send_item(OP_INSERT, 8'd0, 1'b0, 8'd0, OBJ_IN_BITS'($urandom_range(65535)));
        send_item(OP_REMOVE, pick_mapped(), 1'b0, 8'd0, 16'h0000);
        send_item(OP_DUP, pick_mapped(), 1'b1, pick_stacked(), 16'h0000);
        send_item(OP_INSERT, 8'd0, 1'b0, 8'd0, 16'h0000);  // stack empty, counter at the end
    endtask

    // segments with different op mixes so the table both fills and drains
    task automatic test_random_churn();
        int goal;
        int seg_len;
        goal = items_sent + RANDOM_ITEMS;
        while (items_sent < goal) begin
            seg_len = $urandom_range(40, 160);
            case ($urandom_range(3))
                0: begin
                    seg_len = $urandom_range(100, 320);
                    repeat (seg_len) if (items_sent < goal) send_random_item(60, 15, 25);
                end
                1:       repeat (seg_len) if (items_sent < goal) send_random_item(20, 55, 23);
                2:       repeat (seg_len) if (items_sent < goal) send_random_item(25, 20, 53);
                default: repeat (seg_len) if (items_sent < goal) send_random_item(40, 30, 28);
            endcase
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                want = '0;
                log_mismatch("result with nothing pending", want, m_tdata);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[7:0] != want.hnd)
                    log_mismatch("result_handle", want, m_tdata);
                else if (status_t'(m_tdata[9:8]) != want.st)
                    log_mismatch("status", want, m_tdata);
            end
        end
    end

    // receiver stall pattern; bits 10:9 of the cycle count pick one of four characters
    int stall_cycle = 0;
    int stall_hold  = 0;
    always @(negedge aclk) begin
        stall_cycle++;
        case ((stall_cycle >> 9) % 4)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(9) < 7);
            2: m_tready <= ($urandom_range(3) == 0);
            default: begin
                if (stall_hold == 0) begin
                    m_tready   <= ~m_tready;
                    stall_hold = $urandom_range(1, 20);
                end else begin
                    stall_hold--;
                end
            end
        endcase
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_count = 0;
        else
            quiet_count++;
        if (quiet_count >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        foreach (map_valid[i]) begin
            map_valid[i] = 1'b0;
            map_obj[i]   = '0;
            free_lifo[i] = '0;
        end
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_basic_ops();
        test_dup_cases();
        test_fill_to_full();
        test_random_churn();

        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[handle_table_allocator.f]
rtl/core/hta_pkg.sv
rtl/core/hta_ram.sv
rtl/core/handle_table_allocator.sv
dv/tb_handle_table_allocator.sv
